### rtl/two_phase_led_fade_pwm_macros.svh
// Assertion macros used by the checker file of the LED fade block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef TWO_PHASE_LED_FADE_PWM_MACROS_SVH
`define TWO_PHASE_LED_FADE_PWM_MACROS_SVH

// Checked at every clock edge outside reset.
`define TPLFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tplfp assertion failed");

// Checked at every clock edge, reset included.
`define TPLFP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tplfp assertion failed");

`endif

### rtl/tplfp_pkg.sv
// Constants, level tables and lookup functions of the LED fade block.
// No dependencies; used by the top level.
package tplfp_pkg;

  localparam int unsigned LEVEL_TABLE_SIZE = 12;
  localparam int unsigned MODE_COUNT       = 5;
  localparam int unsigned ROW_LEN          = 12;

  typedef logic [2:0] mode_t;
  typedef logic [5:0] index_t;
  typedef logic [4:0] level_t;

  typedef enum logic {
    FUNC_TICK   = 1'b0,
    FUNC_TOGGLE = 1'b1
  } func_e;

  typedef enum logic {
    CFG_FADE_MODE   = 1'b0,
    CFG_ENABLE_INIT = 1'b1
  } cfg_idx_e;

  localparam mode_t      MODE_RESET        = 3'd4;
  localparam logic [15:0] ENABLE_INIT_RESET = 16'hFFFF;
  localparam logic [5:0] SLOT_TOP          = 6'd32;
  localparam logic [3:0] FRAMES_PER_STEP   = 4'd10;
  localparam logic [7:0] PAT_LOW           = 8'h0F;
  localparam logic [7:0] PAT_HIGH          = 8'hF0;
  localparam index_t     START_ONE         = 6'd0;
  localparam index_t     PHASE_TWO_RESET   = 6'd6;

  localparam level_t LEVELS [MODE_COUNT][ROW_LEN] = '{
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd1, 5'd3, 5'd3, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd1, 5'd3, 5'd3, 5'd7, 5'd3, 5'd3, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd1, 5'd3, 5'd3, 5'd7, 5'd15, 5'd31, 5'd15, 5'd7, 5'd3, 5'd3, 5'd1}
  };

  localparam index_t START_TWO [MODE_COUNT] = '{6'd1, 6'd1, 6'd2, 6'd4, 6'd6};

  localparam index_t MAX_COUNT [MODE_COUNT] = '{
    index_t'(LEVEL_TABLE_SIZE + 28),
    index_t'(LEVEL_TABLE_SIZE + 28),
    index_t'(LEVEL_TABLE_SIZE + 18),
    index_t'(LEVEL_TABLE_SIZE + 18),
    index_t'(LEVEL_TABLE_SIZE + 20)
  };

  localparam level_t TOP_REMAP [16] = '{
    5'd0, 5'd16, 5'd0, 5'd24, 5'd0, 5'd0, 5'd0, 5'd28,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd30
  };

  // Levels past the end of the table read as zero.
  function automatic level_t level_at(mode_t mode, index_t idx);
    level_t lvl;
    lvl = '0;
    if ((32'(idx) < LEVEL_TABLE_SIZE) && (32'(idx) < ROW_LEN)) begin
      lvl = LEVELS[mode][idx[3:0]];
    end
    return lvl;
  endfunction

  // Levels below 16 are turned into bits counted from the top slot.
  function automatic level_t remap_top(level_t lvl);
    level_t res;
    res = lvl;
    if (!lvl[4]) begin
      res = TOP_REMAP[lvl[3:0]];
    end
    return res;
  endfunction

endpackage

### rtl/tplfp_in_if.sv
// Input channel of the LED fade block: valid/ready handshake with the item fields.
// No dependencies.
interface tplfp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [3:0] button_index;

  modport source (output valid, output func, output button_index, input ready);
  modport sink (input valid, input func, input button_index, output ready);
endinterface

### rtl/tplfp_out_if.sv
// Result channel of the LED fade block: valid/ready handshake with the result fields.
// No dependencies.
interface tplfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  port_low;
  logic [7:0]  port_high;
  logic [15:0] enable_bits;

  modport source (output valid, output port_low, output port_high, output enable_bits,
                  input ready);
  modport sink (input valid, input port_low, input port_high, input enable_bits,
                output ready);
endinterface

### rtl/two_phase_led_fade_pwm.sv
// Top level of the two-phase LED fade generator with 5-bit PWM.
// Depends on tplfp_pkg, tplfp_in_if and tplfp_out_if.
//
// Usage: every word on in_i is either a one millisecond tick (func = 0) or a
// toggle of one button's enable bit (func = 1). Each accepted word yields
// exactly one word on out_o: for a tick, the pattern of the previous tick
// masked by the enable bits; for a toggle, zero ports and the new mask.
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_data_i while the block
// is idle: register 0 takes fade mode 0 to 4 and reloads both phase indices
// and the enable mask, register 1 holds the enable mask that such a load uses.
// A word accepted at one edge is shown on out_o after that edge unless out_o
// stalls. Throughput is one word per cycle while out_o is taken, set by the
// single register stage that updates the fade state and the result register.
// When the receiver stalls, one more word is taken into a skid register and
// in_i.ready then drops until the receiver takes a word.
// Reset selects mode 4, sets all enable bits, clears the slot shifter, frame
// counter, levels and pattern, and empties the result and skid registers.
module two_phase_led_fade_pwm #(
  parameter int unsigned NUM_BUTTONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  tplfp_in_if.sink    in_i,
  tplfp_out_if.source out_o
);

  localparam int unsigned EnW = (NUM_BUTTONS > 16) ? NUM_BUTTONS : 16;

  typedef struct packed {
    logic [7:0]  port_low;
    logic [7:0]  port_high;
    logic [15:0] enable_bits;
  } word_t;

  tplfp_pkg::mode_t       mode_q;
  logic [15:0]            enable_init_q;
  logic [NUM_BUTTONS-1:0] enable_q;
  logic [5:0]             slot_q, slot_d;
  logic [3:0]             frame_q, frame_d, frame_inc;
  tplfp_pkg::index_t      p1_idx_q, p1_idx_d, p1_inc;
  tplfp_pkg::index_t      p2_idx_q, p2_idx_d, p2_inc;
  tplfp_pkg::level_t      p1_lvl_q, p1_lvl_d;
  tplfp_pkg::level_t      p2_lvl_q, p2_lvl_d;
  logic [7:0]             pattern_q, pattern_d;

  logic [NUM_BUTTONS-1:0] toggle_vec;
  logic [EnW-1:0]         en_cur, en_tog;
  logic                   is_toggle;
  logic                   in_fire, out_fire;
  logic                   load_out_new, load_out_skid, load_skid;
  logic                   out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  word_t                  result_word, out_q, skid_q;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_fire  = out_valid_q && out_o.ready;
  assign is_toggle = (in_i.func == tplfp_pkg::FUNC_TOGGLE);

  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      toggle_vec[b] = (32'(in_i.button_index) == b);
    end
  end

  assign en_cur = EnW'(enable_q);
  assign en_tog = EnW'(enable_q ^ toggle_vec);

  assign frame_inc = frame_q + 4'd1;
  assign p1_inc    = p1_idx_q + 6'd1;
  assign p2_inc    = p2_idx_q + 6'd1;

  always_comb begin
    slot_d   = slot_q >> 1;
    frame_d  = frame_q;
    p1_idx_d = p1_idx_q;
    p2_idx_d = p2_idx_q;
    p1_lvl_d = p1_lvl_q;
    p2_lvl_d = p2_lvl_q;
    if (slot_q == '0) begin
      slot_d  = tplfp_pkg::SLOT_TOP;
      frame_d = frame_inc;
      if (frame_inc >= tplfp_pkg::FRAMES_PER_STEP) begin
        frame_d  = '0;
        p1_idx_d = (p1_inc > tplfp_pkg::MAX_COUNT[mode_q]) ? '0 : p1_inc;
        p2_idx_d = (p2_inc > tplfp_pkg::MAX_COUNT[mode_q]) ? '0 : p2_inc;
        p1_lvl_d = tplfp_pkg::level_at(mode_q, p1_idx_d);
        p2_lvl_d = tplfp_pkg::remap_top(tplfp_pkg::level_at(mode_q, p2_idx_d));
      end
    end
    pattern_d = ((|({1'b0, p1_lvl_d} & slot_d)) ? tplfp_pkg::PAT_LOW : 8'h00) |
                ((|({1'b0, p2_lvl_d} & slot_d)) ? tplfp_pkg::PAT_HIGH : 8'h00);
  end

  always_comb begin
    if (is_toggle) begin
      result_word.port_low    = 8'h00;
      result_word.port_high   = 8'h00;
      result_word.enable_bits = en_tog[15:0];
    end else begin
      result_word.port_low    = pattern_q & en_cur[7:0];
      result_word.port_high   = pattern_q & en_cur[15:8];
      result_word.enable_bits = en_cur[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= tplfp_pkg::MODE_RESET;
      enable_init_q <= tplfp_pkg::ENABLE_INIT_RESET;
      enable_q      <= '1;
      slot_q        <= '0;
      frame_q       <= '0;
      p1_idx_q      <= tplfp_pkg::START_ONE;
      p2_idx_q      <= tplfp_pkg::PHASE_TWO_RESET;
      p1_lvl_q      <= '0;
      p2_lvl_q      <= '0;
      pattern_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tplfp_pkg::CFG_FADE_MODE: begin
          if (cfg_data_i[2:0] < 3'(tplfp_pkg::MODE_COUNT)) begin
            mode_q   <= cfg_data_i[2:0];
            enable_q <= NUM_BUTTONS'(enable_init_q);
            p1_idx_q <= tplfp_pkg::START_ONE;
            p2_idx_q <= tplfp_pkg::START_TWO[cfg_data_i[2:0]];
          end
        end
        tplfp_pkg::CFG_ENABLE_INIT: begin
          enable_init_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      if (is_toggle) begin
        enable_q <= enable_q ^ toggle_vec;
      end else begin
        slot_q    <= slot_d;
        frame_q   <= frame_d;
        p1_idx_q  <= p1_idx_d;
        p2_idx_q  <= p2_idx_d;
        p1_lvl_q  <= p1_lvl_d;
        p2_lvl_q  <= p2_lvl_d;
        pattern_q <= pattern_d;
      end
    end
  end

  // A new word is accepted only while the skid register is empty.
  assign load_out_new  = in_fire && (!out_valid_q || out_fire);
  assign load_skid     = in_fire && out_valid_q && !out_fire;
  assign load_out_skid = skid_valid_q && out_fire;
  assign out_valid_d   = load_out_new || load_out_skid || (out_valid_q && !out_fire);
  assign skid_valid_d  = load_skid || (skid_valid_q && !out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_new) begin
      out_q <= result_word;
    end else if (load_out_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= result_word;
    end
  end

  assign in_i.ready        = !skid_valid_q;
  assign out_o.valid       = out_valid_q;
  assign out_o.port_low    = out_q.port_low;
  assign out_o.port_high   = out_q.port_high;
  assign out_o.enable_bits = out_q.enable_bits;

endmodule

### rtl/tplfp_checker.sv
// Port-level checker of the LED fade block and its bind to the top level.
// Depends on two_phase_led_fade_pwm_macros.svh.
`include "two_phase_led_fade_pwm_macros.svh"

module tplfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  port_low,
  input logic [7:0]  port_high,
  input logic [15:0] enable_bits
);

  logic [31:0] res_word;
  logic [15:0] port_drive;

  assign res_word   = {port_low, port_high, enable_bits};
  assign port_drive = {port_high, port_low};

  // A stalled result word holds until it is taken.
  `TPLFP_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(res_word))

  // An accepted word leaves a result word pending in the next cycle.
  `TPLFP_ASSERT(a_accept_valid, in_valid && in_ready |=> out_valid)

  // A port bit is driven only where its button is enabled.
  `TPLFP_ASSERT(a_enabled, out_valid |-> (port_drive & ~enable_bits) == 16'd0)

  // With no result pending the block can always take a word.
  `TPLFP_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready)

endmodule

bind two_phase_led_fade_pwm tplfp_checker u_tplfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .port_low    (out_o.port_low),
  .port_high   (out_o.port_high),
  .enable_bits (out_o.enable_bits)
);

### dv/tb_two_phase_led_fade_pwm.sv
// Self-checking testbench for the two-phase LED fade PWM block.
// Depends on tplfp_pkg, tplfp_in_if and tplfp_out_if; predicts every result word
// from its own fade model and compares it with the block's output channel.
module tb_two_phase_led_fade_pwm;
  timeunit 1ns;
  timeprecision 1ps;

  typedef tplfp_pkg::mode_t    mode_t;
  typedef tplfp_pkg::index_t   index_t;
  typedef tplfp_pkg::level_t   level_t;
  typedef tplfp_pkg::func_e    func_e;
  typedef tplfp_pkg::cfg_idx_e cfg_idx_e;

  localparam int unsigned FADE_MODES  = 5;
  localparam int unsigned LEVEL_DEPTH = 12;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT = 50;

  localparam mode_t FADE_FLAT  = 3'd0;
  localparam mode_t FADE_BLIP  = 3'd1;
  localparam mode_t FADE_SHORT = 3'd2;
  localparam mode_t FADE_MID   = 3'd3;
  localparam mode_t FADE_FULL  = 3'd4;
  localparam mode_t FADE_RSVD5 = 3'd5;
  localparam mode_t FADE_RSVD6 = 3'd6;
  localparam mode_t FADE_RSVD7 = 3'd7;

  localparam logic [4:0] FADE_LEVELS [FADE_MODES][LEVEL_DEPTH] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 3, 3, 1, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 3, 3, 7, 3, 3, 1, 0, 0, 0, 0},
    '{0, 1, 3, 3, 7, 15, 31, 15, 7, 3, 3, 1}
  };
  localparam logic [5:0] FADE_START_TWO [FADE_MODES] = '{1, 1, 2, 4, 6};
  localparam logic [5:0] FADE_WRAP [FADE_MODES]      = '{40, 40, 30, 30, 32};
  localparam logic [4:0] TOP_BITS [16] = '{
    0, 16, 0, 24, 0, 0, 0, 28, 0, 0, 0, 0, 0, 0, 0, 30
  };

  typedef struct packed {
    func_e      func;
    logic [3:0] button;
  } fade_word_t;

  typedef struct packed {
    logic [7:0]  port_low;
    logic [7:0]  port_high;
    logic [15:0] enable_bits;
  } fade_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  tplfp_in_if  in_ch ();
  tplfp_out_if out_ch ();

  two_phase_led_fade_pwm #(
    .NUM_BUTTONS(16)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  fade_word_t   word_q [$];
  fade_result_t expected_q [$];

  mode_t       fm_mode;
  logic [15:0] fm_init;
  logic [15:0] fm_mask;
  logic [5:0]  fm_slot;
  logic [3:0]  fm_frame;
  index_t      fm_idx_one;
  index_t      fm_idx_two;
  level_t      fm_lvl_one;
  level_t      fm_lvl_two;
  logic [7:0]  fm_pattern;

  int unsigned mismatches;
  int unsigned words_out;
  int unsigned tick_count;
  int unsigned toggle_count;
  int unsigned reg_writes;
  int unsigned bad_mode_writes;
  int unsigned settings_run;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  bit          hold_done;
  bit          no_idle;

  function automatic fade_result_t fade_next(fade_word_t w);
    fade_result_t r;
    if (w.func == tplfp_pkg::FUNC_TOGGLE) begin
      fm_mask[w.button] = ~fm_mask[w.button];
      r = '{8'h00, 8'h00, fm_mask};
      return r;
    end
    r = '{fm_pattern & fm_mask[7:0], fm_pattern & fm_mask[15:8], fm_mask};
    if (fm_slot == 6'd0) begin
      fm_slot  = 6'd32;
      fm_frame = fm_frame + 4'd1;
      if (fm_frame >= 4'd10) begin
        fm_frame   = 4'd0;
        fm_idx_one = fm_idx_one + 6'd1;
        if (fm_idx_one > FADE_WRAP[fm_mode]) fm_idx_one = 6'd0;
        fm_lvl_one = (fm_idx_one < LEVEL_DEPTH) ? FADE_LEVELS[fm_mode][fm_idx_one] : 5'd0;
        fm_idx_two = fm_idx_two + 6'd1;
        if (fm_idx_two > FADE_WRAP[fm_mode]) fm_idx_two = 6'd0;
        fm_lvl_two = (fm_idx_two < LEVEL_DEPTH) ? FADE_LEVELS[fm_mode][fm_idx_two] : 5'd0;
        if (!fm_lvl_two[4]) fm_lvl_two = TOP_BITS[fm_lvl_two[3:0]];
      end
    end else begin
      fm_slot = fm_slot >> 1;
    end
    fm_pattern = ((({1'b0, fm_lvl_one} & fm_slot) != 6'd0) ? 8'h0F : 8'h00) |
                 ((({1'b0, fm_lvl_two} & fm_slot) != 6'd0) ? 8'hF0 : 8'h00);
    return r;
  endfunction

  function automatic void fade_config(cfg_idx_e idx, logic [15:0] data);
    if (idx == tplfp_pkg::CFG_FADE_MODE) begin
      if (data[2:0] < FADE_MODES) begin
        fm_mode    = data[2:0];
        fm_mask    = fm_init;
        fm_idx_one = 6'd0;
        fm_idx_two = FADE_START_TWO[data[2:0]];
      end
    end else begin
      fm_init = data;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    fade_config(idx, data);
    reg_writes++;
    if (idx == tplfp_pkg::CFG_FADE_MODE && data[2:0] >= FADE_MODES) bad_mode_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (word_q.size() != 0 || expected_q.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic queue_word(input func_e f, input logic [3:0] b);
    fade_word_t w;
    w.func   = f;
    w.button = b;
    word_q.push_back(w);
  endtask

  task automatic run_phase(input mode_t mode, input logic [15:0] init, input int unsigned n,
                           input int unsigned toggle_pct);
    wait_idle();
    write_reg(tplfp_pkg::CFG_ENABLE_INIT, init);
    write_reg(tplfp_pkg::CFG_FADE_MODE, {13'd0, mode});
    settings_run++;
    src_idle_pct  = 12 * $urandom_range(0, 3);
    sink_idle_pct = 12 * $urandom_range(0, 3);
    @(negedge clk_i);
    repeat (n) begin
      queue_word(($urandom_range(0, 99) < toggle_pct) ? tplfp_pkg::FUNC_TOGGLE
                                                      : tplfp_pkg::FUNC_TICK,
                 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    fade_word_t w;
    if (in_ch.valid && in_ch.ready) begin
      w = word_q.pop_front();
      expected_q.push_back(fade_next(w));
      if (w.func == tplfp_pkg::FUNC_TICK) tick_count++;
      else toggle_count++;
    end
    if (in_ch.valid && !in_ch.ready) begin
    end else if (src_gap > 0) begin
      src_gap--;
      in_ch.valid <= 1'b0;
    end else if (!no_idle && word_q.size() > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      src_gap = $urandom_range(0, 11);
      in_ch.valid <= 1'b0;
    end else if (word_q.size() > 0) begin
      in_ch.valid        <= 1'b1;
      in_ch.func         <= word_q[0].func;
      in_ch.button_index <= word_q[0].button;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    fade_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      words_out++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h %h %h", out_ch.port_low,
                                  out_ch.port_high, out_ch.enable_bits));
      end else begin
        want = expected_q.pop_front();
        if (out_ch.port_low !== want.port_low)
          report_mismatch($sformatf("word %0d port_low %h, want %h", words_out,
                                    out_ch.port_low, want.port_low));
        if (out_ch.port_high !== want.port_high)
          report_mismatch($sformatf("word %0d port_high %h, want %h", words_out,
                                    out_ch.port_high, want.port_high));
        if (out_ch.enable_bits !== want.enable_bits)
          report_mismatch($sformatf("word %0d enable_bits %h, want %h", words_out,
                                    out_ch.enable_bits, want.enable_bits));
      end
    end
    if (!hold_done && words_out >= 250) begin
      hold_done = 1'b1;
      hold_left = 80;
    end
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < sink_idle_pct) begin
      sink_gap = $urandom_range(0, 11);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("No handshake for %0d cycles, %0d words pending.", quiet_cycles,
                   word_q.size() + expected_q.size());
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = tplfp_pkg::CFG_FADE_MODE;
    cfg_data_i         = 16'h0000;
    in_ch.valid        = 1'b0;
    in_ch.func         = tplfp_pkg::FUNC_TICK;
    in_ch.button_index = 4'd0;
    out_ch.ready       = 1'b0;
    fm_mode    = FADE_FULL;
    fm_init    = 16'hFFFF;
    fm_mask    = 16'hFFFF;
    fm_slot    = 6'd0;
    fm_frame   = 4'd0;
    fm_idx_one = 6'd0;
    fm_idx_two = 6'd6;
    fm_lvl_one = 5'd0;
    fm_lvl_two = 5'd0;
    fm_pattern = 8'h00;
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    queue_word(tplfp_pkg::FUNC_TICK, 4'd0);
    queue_word(tplfp_pkg::FUNC_TICK, 4'd15);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd0);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd15);
    queue_word(tplfp_pkg::FUNC_TICK, 4'd9);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd15);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd0);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd10);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd5);
    queue_word(tplfp_pkg::FUNC_TICK, 4'd6);
    wait_idle();
    write_reg(tplfp_pkg::CFG_ENABLE_INIT, 16'h0000);
    write_reg(tplfp_pkg::CFG_FADE_MODE, {13'd0, FADE_FLAT});
    @(negedge clk_i);
    queue_word(tplfp_pkg::FUNC_TICK, 4'd0);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd3);
    queue_word(tplfp_pkg::FUNC_TICK, 4'd0);
    wait_idle();
    write_reg(tplfp_pkg::CFG_FADE_MODE, {13'd0, FADE_RSVD7});
    @(negedge clk_i);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd3);
    queue_word(tplfp_pkg::FUNC_TICK, 4'd0);
    wait_idle();
    write_reg(tplfp_pkg::CFG_ENABLE_INIT, 16'hFFFF);
    write_reg(tplfp_pkg::CFG_FADE_MODE, {13'd0, FADE_RSVD5});
    write_reg(tplfp_pkg::CFG_FADE_MODE, {13'd0, FADE_RSVD6});
    @(negedge clk_i);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd12);
    queue_word(tplfp_pkg::FUNC_TICK, 4'd0);
    wait_idle();
    write_reg(tplfp_pkg::CFG_FADE_MODE, {13'd0, FADE_FULL});
    @(negedge clk_i);
    queue_word(tplfp_pkg::FUNC_TICK, 4'd0);
    queue_word(tplfp_pkg::FUNC_TOGGLE, 4'd1);

    run_phase(FADE_FULL, 16'($urandom), 150, 10);
    run_phase(FADE_MID, 16'hFFFF, 650, 8);
    run_phase(FADE_FLAT, 16'h0000, 60, 30);
    run_phase(mode_t'($urandom_range(0, 7)), 16'($urandom), 80, 20);
    run_phase(FADE_BLIP, 16'h00FF, 80, 15);
    run_phase(FADE_SHORT, 16'hFF00, 160, 10);
    no_idle = 1'b1;
    run_phase(FADE_FULL, 16'($urandom), 120, 15);

    do @(negedge clk_i); while (word_q.size() != 0 || expected_q.size() != 0);
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d ticks and %0d toggles over %0d random fade settings.",
             tick_count, toggle_count, settings_run);
    $display("%0d register writes (%0d invalid mode values), %0d result words checked.",
             reg_writes, bad_mode_writes, words_out);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
